[hdl/pwc_pkg.sv]
// ----------------------------------------------------------------------------
// pwc_pkg
// Shared types and constants of the pulse wave channel: register codes,
// controller states, command and status bundles, duty and length tables.
// ----------------------------------------------------------------------------
package pwc_pkg;

	localparam int SR_W     = 16;
	localparam int CPU_W    = 21;
	localparam int FR_W     = 9;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W    = 21;

	localparam int ENV_W    = 20;
	localparam int SWL_W    = 19;
	localparam int LEN_W    = 24;
	localparam int PHASE_W  = 28;
	localparam int WP_W     = 16;
	localparam int TIMER_W  = 11;
	localparam int ACC_W    = 21;
	localparam int MULA_W   = 11;
	localparam int PROD_W   = MULA_W + SR_W;
	localparam int DVD_W    = 21;

	localparam int DIV_STEPS = DVD_W;
	localparam int CNT_W     = 5;

	localparam logic [SR_W-1:0]  SR_RESET  = 16'd44100;
	localparam logic [CPU_W-1:0] CPU_RESET = 21'd1789772;
	localparam logic [FR_W-1:0]  FR_RESET  = 9'd240;

	localparam logic [CFG_IDX_W-1:0] CFG_OUT_RATE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CPU_CLOCK  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_RATE = 2'd2;

	localparam logic [2:0] REG_DUTY     = 3'd0;
	localparam logic [2:0] REG_SWEEP    = 3'd1;
	localparam logic [2:0] REG_TIMER_LO = 3'd2;
	localparam logic [2:0] REG_TIMER_HI = 3'd3;
	localparam logic [2:0] REG_ENABLE   = 3'd4;

	localparam logic [WP_W-1:0] PERIOD_MAX = 16'h07FF;
	localparam logic [WP_W-1:0] PERIOD_MIN = 16'd8;

	localparam logic [7:0] DUTY_MASK [4] = '{8'h40, 8'h60, 8'h78, 8'h9F};

	localparam logic [7:0] LEN_TABLE [32] = '{
		8'd10, 8'd254, 8'd20, 8'd2, 8'd40, 8'd4, 8'd80, 8'd6,
		8'd160, 8'd8, 8'd60, 8'd10, 8'd14, 8'd12, 8'd26, 8'd14,
		8'd12, 8'd16, 8'd24, 8'd18, 8'd48, 8'd20, 8'd96, 8'd22,
		8'd192, 8'd24, 8'd72, 8'd26, 8'd16, 8'd28, 8'd32, 8'd30
	};

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WRITE,
		ST_WLEN,
		ST_TICK,
		ST_ENV_LOOP,
		ST_LEN,
		ST_SWP,
		ST_RANGE,
		ST_SEQ,
		ST_DIV,
		ST_FIX,
		ST_EMIT_ZERO,
		ST_EMIT_LEVEL
	} state_t;

	typedef enum logic [1:0] {
		MUL_LEN,
		MUL_ENV,
		MUL_SWP,
		MUL_SEQ
	} mul_sel_t;

	typedef struct packed {
		logic     take_item;
		logic     do_write;
		logic     load_len;
		mul_sel_t mul_sel;
		logic     env_init;
		logic     env_step;
		logic     env_store;
		logic     len_update;
		logic     swp_init;
		logic     swp_step;
		logic     swp_store;
		logic     seq_start;
		logic     div_step;
		logic     div_fix;
		logic     load_out;
		logic     out_zero;
	} cmd_t;

	typedef struct packed {
		logic chan_on;
		logic acc_neg;
		logic len_zero_next;
		logic sweep_on;
		logic period_bad;
		logic phase_ge;
		logic out_free;
	} status_t;

endpackage

[hdl/pwc_ctrl.sv]
// ----------------------------------------------------------------------------
// pwc_ctrl
// Controller of the pulse wave channel: sequences register writes and the
// envelope, length, sweep, sequencer, divide and emit phases of a sample tick.
// ----------------------------------------------------------------------------
module pwc_ctrl
	import pwc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	input  logic    kind,
	output logic    item_stall,
	input  status_t st,
	output cmd_t    cmd
);

	state_t state_q;
	state_t state_nxt;
	logic [CNT_W-1:0] cnt_q;
	logic div_last;

	assign div_last = (cnt_q == CNT_W'(DIV_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_SEQ) begin
				cnt_q <= '0;
			end else if (state_q == ST_DIV) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_comb begin
		state_nxt   = state_q;
		cmd         = '0;
		cmd.mul_sel = MUL_SEQ;
		item_stall  = 1'b1;
		case (state_q)
			ST_IDLE: begin
				item_stall    = 1'b0;
				cmd.take_item = item_valid;
				if (item_valid) begin
					state_nxt = kind ? ST_WRITE : ST_TICK;
				end
			end
			ST_WRITE: begin
				cmd.do_write = 1'b1;
				cmd.mul_sel  = MUL_LEN;
				state_nxt    = ST_WLEN;
			end
			ST_WLEN: begin
				cmd.load_len = 1'b1;
				state_nxt    = ST_IDLE;
			end
			ST_TICK: begin
				cmd.mul_sel = MUL_ENV;
				if (!st.chan_on) begin
					state_nxt = ST_EMIT_ZERO;
				end else begin
					cmd.env_init = 1'b1;
					state_nxt    = ST_ENV_LOOP;
				end
			end
			ST_ENV_LOOP: begin
				cmd.mul_sel = MUL_ENV;
				if (st.acc_neg) begin
					cmd.env_step = 1'b1;
				end else begin
					cmd.env_store = 1'b1;
					state_nxt     = ST_LEN;
				end
			end
			ST_LEN: begin
				cmd.len_update = 1'b1;
				cmd.swp_init   = 1'b1;
				cmd.mul_sel    = MUL_SWP;
				state_nxt      = st.len_zero_next ? ST_EMIT_ZERO : ST_SWP;
			end
			ST_SWP: begin
				cmd.mul_sel = MUL_SWP;
				if (!st.sweep_on) begin
					state_nxt = ST_RANGE;
				end else if (st.acc_neg) begin
					cmd.swp_step = 1'b1;
				end else begin
					cmd.swp_store = 1'b1;
					state_nxt     = ST_RANGE;
				end
			end
			ST_RANGE: begin
				state_nxt = st.period_bad ? ST_EMIT_ZERO : ST_SEQ;
			end
			ST_SEQ: begin
				cmd.seq_start = 1'b1;
				state_nxt     = st.phase_ge ? ST_EMIT_LEVEL : ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (div_last) begin
					state_nxt = ST_FIX;
				end
			end
			ST_FIX: begin
				cmd.div_fix = 1'b1;
				state_nxt   = ST_EMIT_LEVEL;
			end
			ST_EMIT_ZERO: begin
				if (st.out_free) begin
					cmd.load_out = 1'b1;
					cmd.out_zero = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			ST_EMIT_LEVEL: begin
				if (st.out_free) begin
					cmd.load_out = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

[hdl/pwc_dp.sv]
// ----------------------------------------------------------------------------
// pwc_dp
// Datapath of the pulse wave channel: configuration and channel registers,
// shared rate multiplier, envelope/sweep accumulator, restoring divider for
// the sequencer and the output register.
// ----------------------------------------------------------------------------
module pwc_dp
	import pwc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	input  logic [2:0]            reg_index,
	input  logic [7:0]            data,
	input  cmd_t                  cmd,
	output status_t               st,
	output logic                  sample_valid,
	input  logic                  sample_stall,
	output logic signed [4:0]     sample
);

	// configuration
	logic [SR_W-1:0]  sr_q;
	logic [CPU_W-1:0] cpu_q;
	logic [FR_W-1:0]  fr_q;
	logic [SR_W-1:0]  sr_eff;

	// channel state
	logic [7:0]         ctrl_q;
	logic [7:0]         sweep_q;
	logic [TIMER_W-1:0] timer_q;
	logic               on_q;
	logic [3:0]         step_q;
	logic [4:0]         decay_q;
	logic [WP_W-1:0]    wp_q;
	logic [LEN_W-1:0]   len_q;
	logic [ENV_W-1:0]   env_q;
	logic [SWL_W-1:0]   swl_q;
	logic [PHASE_W-1:0] phase_q;

	// working registers
	logic [2:0]        reg_q;
	logic [7:0]        data_q;
	logic [PROD_W-1:0] prod_q;
	logic [ACC_W-1:0]  acc_q;
	logic [DVD_W-1:0]  dvd_q;
	logic [DVD_W-1:0]  rem_q;
	logic [3:0]        q4_q;

	logic              out_valid_q;
	logic signed [4:0] sample_q;

	logic [MULA_W-1:0] mul_a;
	logic [WP_W-1:0]   shifted;
	logic [WP_W:0]     wp_sum;
	logic [WP_W-1:0]   wp_swp;
	logic [LEN_W-1:0]  len_nxt;
	logic [DVD_W:0]    trial;
	logic              fits;
	logic [DVD_W-1:0]  rem_nxt;
	logic [4:0]        decay_nxt;
	logic [3:0]        level;
	logic [7:0]        mask;
	logic              high;
	logic [4:0]        lvl5;
	logic signed [4:0] level_out;
	logic [3:0]        n4;

	assign sr_eff = (sr_q == '0) ? SR_W'(1) : sr_q;

	always_comb begin
		case (cmd.mul_sel)
			MUL_LEN: mul_a = MULA_W'(LEN_TABLE[data_q[7:3]]);
			MUL_ENV: mul_a = MULA_W'({1'b0, ctrl_q[3:0]} + 5'd1);
			MUL_SWP: mul_a = MULA_W'({1'b0, sweep_q[6:4]} + 4'd1);
			MUL_SEQ: mul_a = wp_q[MULA_W-1:0];
			default: mul_a = '0;
		endcase
	end

	// sweep adjustment
	always_comb begin
		shifted = wp_q >> sweep_q[2:0];
		wp_sum  = {1'b0, wp_q} + {1'b0, shifted};
		if (sweep_q[3]) begin
			wp_swp = wp_q - shifted;
		end else begin
			wp_swp = wp_sum[WP_W] ? '1 : wp_sum[WP_W-1:0];
		end
	end

	// length counter, clamps at zero
	always_comb begin
		len_nxt = len_q;
		if (len_q != '0 && !ctrl_q[5]) begin
			len_nxt = (len_q > LEN_W'(fr_q)) ? len_q - LEN_W'(fr_q) : '0;
		end
	end

	// envelope decay
	always_comb begin
		if (ctrl_q[5]) begin
			decay_nxt = {1'b0, decay_q[3:0] - 4'd1};
		end else if (decay_q != '0) begin
			decay_nxt = decay_q - 5'd1;
		end else begin
			decay_nxt = decay_q;
		end
	end

	// restoring divider step
	always_comb begin
		trial   = {rem_q, dvd_q[DVD_W-1]};
		fits    = PROD_W'(trial) >= prod_q;
		rem_nxt = fits ? DVD_W'(PROD_W'(trial) - prod_q) : trial[DVD_W-1:0];
		n4      = q4_q + {3'b0, rem_q != '0};
	end

	// output level
	always_comb begin
		level     = ctrl_q[4] ? ctrl_q[3:0] : decay_q[3:0];
		mask      = DUTY_MASK[ctrl_q[7:6]];
		high      = mask[~step_q[3:1]];
		lvl5      = {1'b0, level};
		level_out = high ? signed'(lvl5) : signed'(5'd0 - lvl5);
	end

	always_comb begin
		st.chan_on       = on_q;
		st.acc_neg       = acc_q[ACC_W-1];
		st.len_zero_next = (len_nxt == '0);
		st.sweep_on      = sweep_q[7] && (sweep_q[2:0] != 3'd0);
		st.period_bad    = (wp_q > PERIOD_MAX) || (wp_q < PERIOD_MIN);
		st.phase_ge      = phase_q >= PHASE_W'(cpu_q);
		st.out_free      = !out_valid_q || !sample_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sr_q        <= SR_RESET;
			cpu_q       <= CPU_RESET;
			fr_q        <= FR_RESET;
			ctrl_q      <= '0;
			sweep_q     <= '0;
			timer_q     <= '0;
			on_q        <= 1'b0;
			step_q      <= '0;
			decay_q     <= '0;
			wp_q        <= '0;
			len_q       <= '0;
			env_q       <= '0;
			swl_q       <= '0;
			phase_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					CFG_OUT_RATE:   sr_q  <= cfg_data[SR_W-1:0];
					CFG_CPU_CLOCK:  cpu_q <= cfg_data[CPU_W-1:0];
					CFG_FRAME_RATE: fr_q  <= cfg_data[FR_W-1:0];
					default: begin
					end
				endcase
			end
			if (cmd.do_write) begin
				case (reg_q)
					REG_DUTY: ctrl_q <= data_q;
					REG_SWEEP: sweep_q <= data_q;
					REG_TIMER_LO: begin
						timer_q[7:0] <= data_q;
						if (on_q) begin
							wp_q <= WP_W'({timer_q[10:8], data_q}) + WP_W'(1);
						end
					end
					REG_TIMER_HI: begin
						timer_q[10:8] <= data_q[2:0];
						decay_q       <= 5'd16;
						wp_q          <= WP_W'({data_q[2:0], timer_q[7:0]}) + WP_W'(1);
					end
					REG_ENABLE: begin
						on_q <= data_q[0];
						if (!data_q[0]) begin
							len_q <= '0;
						end
					end
					default: begin
					end
				endcase
			end
			if (cmd.load_len && reg_q == REG_TIMER_HI) begin
				len_q <= prod_q[LEN_W-1:0];
			end
			if (cmd.env_step) begin
				decay_q <= decay_nxt;
			end
			if (cmd.env_store) begin
				env_q <= acc_q[ENV_W-1:0];
			end
			if (cmd.len_update) begin
				len_q <= len_nxt;
			end
			if (cmd.swp_step) begin
				wp_q <= wp_swp;
			end
			if (cmd.swp_store) begin
				swl_q <= acc_q[SWL_W-1:0];
			end
			if (cmd.seq_start && st.phase_ge) begin
				phase_q <= phase_q - PHASE_W'(cpu_q);
			end
			if (cmd.div_fix) begin
				phase_q <= (rem_q == '0) ? '0 : PHASE_W'(prod_q - PROD_W'(rem_q));
				step_q  <= step_q + n4;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!sample_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * sr_eff;
		if (cmd.take_item) begin
			reg_q  <= reg_index;
			data_q <= data;
		end
		if (cmd.env_init) begin
			acc_q <= {1'b0, env_q} - ACC_W'(fr_q);
		end else if (cmd.swp_init) begin
			acc_q <= ACC_W'(swl_q) - ACC_W'(fr_q[FR_W-1:1]);
		end else if (cmd.env_step || cmd.swp_step) begin
			acc_q <= acc_q + ACC_W'(prod_q[ENV_W-1:0]);
		end
		if (cmd.seq_start) begin
			dvd_q <= cpu_q - phase_q[DVD_W-1:0];
			rem_q <= '0;
			q4_q  <= '0;
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			rem_q <= rem_nxt;
			q4_q  <= {q4_q[2:0], fits};
		end
		if (cmd.load_out) begin
			sample_q <= cmd.out_zero ? 5'sd0 : level_out;
		end
	end

	assign sample_valid = out_valid_q;
	assign sample       = sample_q;

endmodule

[hdl/pulse_wave_channel.sv]
// ----------------------------------------------------------------------------
// pulse_wave_channel
// Pulse sound channel advanced once per output sample.
// ----------------------------------------------------------------------------
// Input items arrive on item_valid/item_stall with kind, reg_index and data.
// A register write (kind 1) is accepted, applied and followed by a length
// load step, and yields nothing. A sample tick (kind 0) yields one signed
// sample on sample_valid/sample_stall; with the channel off it goes straight
// to a zero sample. The envelope and sweep loops take E and S reload steps
// in a tick (usually 0 or 1, at most frame_rate and frame_rate/2). The
// sequencer step count comes from the one-bit-a-cycle restoring divider, and
// the single rate multiplier is shared by all phases; if the phase needs no
// reload the divider is skipped. One item is worked on at a time;
// item_stall is high while it is. The sample sits in an output register, so
// if sample_stall holds it the channel still takes the next item and only
// waits to deliver the following sample. cfg_write/cfg_index/cfg_data set
// the output rate, the timer clock and the frame rate; the user must write
// them only while the channel is idle, which the block does not enforce.
// Reset clears all channel state and restores 44100, 1789772 and 240.
// ----------------------------------------------------------------------------
module pulse_wave_channel
	import pwc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  logic                  kind,
	input  logic [2:0]            reg_index,
	input  logic [7:0]            data,
	output logic                  sample_valid,
	input  logic                  sample_stall,
	output logic signed [4:0]     sample
);

	cmd_t    cmd;
	status_t st;

	pwc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.kind       (kind),
		.item_stall (item_stall),
		.st         (st),
		.cmd        (cmd)
	);

	pwc_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.reg_index    (reg_index),
		.data         (data),
		.cmd          (cmd),
		.st           (st),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample)
	);

endmodule

[tb/sv/tb_pulse_wave_channel.sv]
// ----------------------------------------------------------------------------
// tb_pulse_wave_channel
// Self-checking bench for the pulse wave channel. Register writes and sample
// ticks go in through the item port, and an in-bench model of the channel
// predicts every sample. Results are compared in order as they leave. The run
// covers the reset rates, the extreme rates, random rates and a zero sample
// rate, with phases of sender gaps, receiver stalls, both together and none,
// and one long receiver hold-off that backs the channel up.
// ----------------------------------------------------------------------------
module tb_pulse_wave_channel;
	import pwc_pkg::*;

	localparam int CYCLE_LIMIT   = 1000000;
	localparam int SETTLE_CYCLES = 16;
	localparam int FINAL_CYCLES  = 64;
	localparam int HOLD_CYCLES   = 300;

	localparam logic KIND_TICK  = 1'b0;
	localparam logic KIND_WRITE = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	localparam logic [2:0] REG_SPARE_LO = 3'd5;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;

	localparam logic [7:0] WAVE_SHAPE [4] = '{8'h40, 8'h60, 8'h78, 8'h9F};
	localparam logic [7:0] NOTE_LENGTH [32] = '{
		8'd10, 8'd254, 8'd20, 8'd2, 8'd40, 8'd4, 8'd80, 8'd6,
		8'd160, 8'd8, 8'd60, 8'd10, 8'd14, 8'd12, 8'd26, 8'd14,
		8'd12, 8'd16, 8'd24, 8'd18, 8'd48, 8'd20, 8'd96, 8'd22,
		8'd192, 8'd24, 8'd72, 8'd26, 8'd16, 8'd28, 8'd32, 8'd30
	};

	logic                 clk;
	logic                 arst_n       = 1'b0;
	logic                 cfg_write    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index    = CFG_OUT_RATE;
	logic [CFG_W-1:0]     cfg_data     = '0;
	logic                 item_valid   = 1'b0;
	logic                 item_stall;
	logic                 kind         = KIND_TICK;
	logic [2:0]           reg_index    = REG_DUTY;
	logic [7:0]           data         = 8'h00;
	logic                 sample_valid;
	logic                 sample_stall = 1'b0;
	logic signed [4:0]    sample;

	pulse_wave_channel u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.kind         (kind),
		.reg_index    (reg_index),
		.data         (data),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample)
	);

	// channel model state
	logic [SR_W-1:0]    mdl_rate;
	logic [CPU_W-1:0]   mdl_cpu;
	logic [FR_W-1:0]    mdl_frame;
	logic [7:0]         mdl_ctrl;
	logic [7:0]         mdl_sweep;
	logic [TIMER_W-1:0] mdl_timer;
	logic               mdl_on;
	logic [3:0]         mdl_step;
	logic [4:0]         mdl_decay;
	logic [WP_W-1:0]    mdl_period;
	logic [LEN_W-1:0]   mdl_length;
	logic [ENV_W-1:0]   mdl_env_left;
	logic [SWL_W-1:0]   mdl_sweep_left;
	logic [PHASE_W-1:0] mdl_phase;

	logic [4:0] expected_levels [$];
	logic [4:0] want_level;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_asks      = 0;
	int hold_seen      = 0;
	int hold_left      = 0;
	int items_sent     = 0;
	int ticks_sent     = 0;
	int samples_seen   = 0;
	int rate_settings  = 0;
	int fail_count     = 0;
	int cycles         = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb: failure");
		$finish;
	end

	function automatic void reset_channel();
		mdl_rate       = SR_RESET;
		mdl_cpu        = CPU_RESET;
		mdl_frame      = FR_RESET;
		mdl_ctrl       = '0;
		mdl_sweep      = '0;
		mdl_timer      = '0;
		mdl_on         = 1'b0;
		mdl_step       = '0;
		mdl_decay      = '0;
		mdl_period     = '0;
		mdl_length     = '0;
		mdl_env_left   = '0;
		mdl_sweep_left = '0;
		mdl_phase      = '0;
	endfunction

	function automatic longint scale_of_rate();
		return (mdl_rate == 0) ? 1 : longint'(mdl_rate);
	endfunction

	function automatic void set_rate_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_W-1:0] value);
		case (idx)
			CFG_OUT_RATE:   mdl_rate  = value[SR_W-1:0];
			CFG_CPU_CLOCK:  mdl_cpu   = value[CPU_W-1:0];
			CFG_FRAME_RATE: mdl_frame = value[FR_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic void apply_write(input logic [2:0] idx, input logic [7:0] value);
		case (idx)
			REG_DUTY: mdl_ctrl = value;
			REG_SWEEP: mdl_sweep = value;
			REG_TIMER_LO: begin
				mdl_timer[7:0] = value;
				if (mdl_on)
					mdl_period = WP_W'(mdl_timer) + 1'b1;
			end
			REG_TIMER_HI: begin
				mdl_timer[10:8] = value[2:0];
				mdl_length = LEN_W'(longint'(NOTE_LENGTH[value[7:3]]) * scale_of_rate());
				mdl_decay  = 5'd16;
				mdl_period = WP_W'(mdl_timer) + 1'b1;
			end
			REG_ENABLE: begin
				mdl_on = value[0];
				if (!mdl_on)
					mdl_length = '0;
			end
			default: ;
		endcase
	endfunction

	function automatic logic [4:0] advance_channel();
		longint     rate;
		longint     acc;
		longint     unit;
		longint     steps;
		int         shift;
		int         grown;
		logic [3:0] level;
		logic       up;
		rate = scale_of_rate();
		if (!mdl_on)
			return 5'd0;

		acc = longint'(mdl_env_left) - longint'(mdl_frame);
		while (acc < 0) begin
			acc += (longint'(mdl_ctrl[3:0]) + 1) * rate;
			if (mdl_ctrl[5])
				mdl_decay = (mdl_decay - 1'b1) & 5'h0F;
			else if (mdl_decay > 0)
				mdl_decay = mdl_decay - 1'b1;
		end
		mdl_env_left = acc[ENV_W-1:0];

		if (mdl_length != 0 && !mdl_ctrl[5]) begin
			if (mdl_length > mdl_frame)
				mdl_length = mdl_length - mdl_frame;
			else
				mdl_length = '0;
		end
		if (mdl_length == 0)
			return 5'd0;

		if (mdl_sweep[7] && mdl_sweep[2:0] != 0) begin
			shift = int'(mdl_sweep[2:0]);
			acc = longint'(mdl_sweep_left) - longint'(mdl_frame >> 1);
			while (acc < 0) begin
				acc += (longint'(mdl_sweep[6:4]) + 1) * rate;
				if (mdl_sweep[3]) begin
					mdl_period = mdl_period - (mdl_period >> shift);
				end else begin
					grown = int'(mdl_period) + int'(mdl_period >> shift);
					mdl_period = (grown > 65535) ? 16'hFFFF : WP_W'(grown);
				end
			end
			mdl_sweep_left = acc[SWL_W-1:0];
		end

		if (mdl_period > PERIOD_MAX || mdl_period < PERIOD_MIN)
			return 5'd0;

		acc = longint'(mdl_phase) - longint'(mdl_cpu);
		if (acc < 0) begin
			unit  = longint'(mdl_period) * rate;
			steps = (-acc + unit - 1) / unit;
			acc  += steps * unit;
			mdl_step = mdl_step + steps[3:0];
		end
		mdl_phase = acc[PHASE_W-1:0];

		level = mdl_ctrl[4] ? mdl_ctrl[3:0] : mdl_decay[3:0];
		up = WAVE_SHAPE[mdl_ctrl[7:6]][3'd7 - mdl_step[3:1]];
		return up ? {1'b0, level} : 5'd0 - {1'b0, level};
	endfunction

	// receiver: random stalls, or a counted hold-off on request
	always @(posedge clk) begin
		if (hold_asks != hold_seen) begin
			hold_seen = hold_asks;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			sample_stall <= 1'b1;
		end else begin
			sample_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && sample_valid && !sample_stall) begin
			if (expected_levels.size() == 0) begin
				$error("sample: none expected, got %0d", sample);
				fail_count++;
			end else begin
				want_level = expected_levels.pop_front();
				samples_seen++;
				if (sample !== want_level) begin
					$error("sample: expected %0d, got %0d", $signed(want_level), sample);
					fail_count++;
				end
			end
		end
	end

	task automatic send_item(input logic k, input logic [2:0] idx, input logic [7:0] value);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		item_valid <= 1'b1;
		kind       <= k;
		reg_index  <= idx;
		data       <= value;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		if (k == KIND_TICK) begin
			expected_levels.push_back(advance_channel());
			ticks_sent++;
		end else begin
			apply_write(idx, value);
		end
		if (!(k == KIND_WRITE && idx > REG_ENABLE))
			items_sent++;
	endtask

	task automatic send_ticks(input int count);
		repeat (count)
			send_item(KIND_TICK, REG_DUTY, 8'($urandom));
	endtask

	task automatic settle_channel();
		item_valid <= 1'b0;
		while (expected_levels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	task automatic configure(input logic [CFG_W-1:0] rate_v, cpu_v, frame_v);
		logic [CFG_IDX_W-1:0] idx_list [4];
		logic [CFG_W-1:0]     val_list [4];
		idx_list = '{CFG_OUT_RATE, CFG_CPU_CLOCK, CFG_FRAME_RATE, CFG_UNUSED};
		val_list = '{rate_v, cpu_v, frame_v, CFG_W'($urandom)};
		for (int i = 0; i < 4; i++) begin
			cfg_write <= 1'b1;
			cfg_index <= idx_list[i];
			cfg_data  <= val_list[i];
			@(posedge clk);
			set_rate_reg(idx_list[i], val_list[i]);
		end
		cfg_write <= 1'b0;
		rate_settings++;
	endtask

	task automatic configure_random();
		configure(CFG_W'($urandom_range(48000, 8000)), CFG_W'($urandom_range(2000000, 1000000)),
			CFG_W'($urandom_range(480, 60)));
	endtask

	// mostly complete notes with random content, the rest loose items
	task automatic play_notes(input int budget);
		int         target;
		logic [7:0] lo;
		logic [7:0] hi;
		logic [7:0] b;
		target = items_sent + budget;
		while (items_sent < target) begin
			if ($urandom_range(99) < 75) begin
				b = 8'($urandom);
				b[0] = 1'b1;
				send_item(KIND_WRITE, REG_ENABLE, b);
				b = 8'($urandom);
				if ($urandom_range(2) == 0)
					b[5] = 1'b0;
				send_item(KIND_WRITE, REG_DUTY, b);
				send_item(KIND_WRITE, REG_SWEEP, 8'($urandom));
				lo = 8'($urandom);
				hi = 8'($urandom);
				case ($urandom_range(9))
					0: begin
						lo = 8'($urandom_range(9));
						hi[2:0] = 3'd0;
					end
					1, 2: hi[7:3] = 5'd3;
					3: hi[2:0] = 3'd7;
					default: ;
				endcase
				send_item(KIND_WRITE, REG_TIMER_LO, lo);
				send_item(KIND_WRITE, REG_TIMER_HI, hi);
				repeat ($urandom_range(40, 4)) begin
					if ($urandom_range(15) == 0)
						send_item(KIND_WRITE, 3'($urandom), 8'($urandom));
					else
						send_item(KIND_TICK, 3'($urandom), 8'($urandom));
				end
			end else begin
				send_item(1'($urandom), 3'($urandom), 8'($urandom));
			end
		end
	endtask

	task automatic test_directed();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		send_ticks(1);
		send_item(KIND_WRITE, REG_SPARE_LO, 8'hFF);
		send_item(KIND_WRITE, REG_SPARE_HI, 8'h00);
		send_item(KIND_WRITE, REG_ENABLE, 8'h01);
		send_item(KIND_WRITE, REG_DUTY, 8'h00);
		send_item(KIND_WRITE, REG_SWEEP, 8'h00);
		send_item(KIND_WRITE, REG_TIMER_LO, 8'hFF);
		send_item(KIND_WRITE, REG_TIMER_HI, 8'hFF);
		send_ticks(1);
		send_item(KIND_WRITE, REG_TIMER_HI, 8'h00);
		send_ticks(2);
		// fresh length load leaves the decay level at sixteen
		send_item(KIND_WRITE, REG_TIMER_HI, 8'h08);
		send_ticks(1);
		send_item(KIND_WRITE, REG_DUTY, 8'hDF);
		send_ticks(1);
		send_item(KIND_WRITE, REG_DUTY, 8'hB5);
		send_item(KIND_WRITE, REG_SWEEP, 8'hFF);
		send_ticks(1);
		send_item(KIND_WRITE, REG_SWEEP, 8'h81);
		send_ticks(1);
		send_item(KIND_WRITE, REG_TIMER_LO, 8'h05);
		send_ticks(1);
		send_item(KIND_WRITE, REG_ENABLE, 8'hFE);
		send_item(KIND_WRITE, REG_TIMER_LO, 8'h80);
		send_ticks(1);
		send_item(KIND_WRITE, REG_ENABLE, 8'h01);
		send_ticks(1);
		settle_channel();
	endtask

	task automatic test_extreme_rates();
		configure(CFG_W'(8000), CFG_W'(2000000), CFG_W'(480));
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		play_notes(300);
		settle_channel();
		configure(CFG_W'(48000), CFG_W'(1000000), CFG_W'(60));
		send_idle_pct = 71;
		play_notes(300);
		settle_channel();
	endtask

	task automatic test_receiver_stalls();
		configure_random();
		send_idle_pct  = 0;
		recv_stall_pct = 71;
		play_notes(300);
		settle_channel();
	endtask

	task automatic test_both_idle();
		configure_random();
		send_idle_pct  = 30;
		recv_stall_pct = 30;
		play_notes(300);
		settle_channel();
	endtask

	task automatic test_backpressure();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		send_item(KIND_WRITE, REG_ENABLE, 8'h01);
		send_item(KIND_WRITE, REG_DUTY, 8'h3A);
		send_item(KIND_WRITE, REG_TIMER_LO, 8'h40);
		send_item(KIND_WRITE, REG_TIMER_HI, 8'h0A);
		hold_asks++;
		send_ticks(16);
		settle_channel();
	endtask

	task automatic test_zero_rate();
		configure(CFG_W'(0), CFG_W'(CPU_RESET), CFG_W'(FR_RESET));
		send_idle_pct  = 30;
		recv_stall_pct = 30;
		play_notes(40);
		settle_channel();
		configure(CFG_W'(SR_RESET), CFG_W'(CPU_RESET), CFG_W'(FR_RESET));
		play_notes(60);
		settle_channel();
	endtask

	initial begin
		reset_channel();
		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_extreme_rates();
		test_receiver_stalls();
		test_both_idle();
		test_backpressure();
		test_zero_rate();

		item_valid <= 1'b0;
		while (expected_levels.size() != 0)
			@(posedge clk);
		repeat (FINAL_CYCLES)
			@(posedge clk);

		$display("summary: %0d items sent, %0d ticks, %0d samples compared", items_sent,
			ticks_sent, samples_seen);
		$display("summary: %0d rate settings, %0d cycles, %0d mismatches", rate_settings,
			cycles, fail_count);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

[files.f]
hdl/pwc_pkg.sv
hdl/pwc_ctrl.sv
hdl/pwc_dp.sv
hdl/pulse_wave_channel.sv
tb/sv/tb_pulse_wave_channel.sv
